FILE: hdl/assert_macros.svh
// Assertion macros shared by the vertex format converter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset
`define VFC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define VFC_ASSERT_IMPLY(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/vfc_pkg.sv
// Types and constants for the vertex format converter
package vfc_pkg;

    localparam int unsigned LAYOUT_MAX_BYTES = 52;
    localparam int unsigned STORE_WORDS      = 13;
    localparam int unsigned STORE_BANKS      = 2;
    localparam int unsigned MAX_STRIDE       = 255;
    localparam int unsigned WORD_ADDR_W      = 4;

    localparam logic [31:0] ONE_FLOAT_BITS = 32'h3f80_0000;
    localparam logic [31:0] WHITE_COLOUR   = 32'hffff_ffff;

    // format word fields
    localparam logic [2:0] POS_XYZ    = 3'b001;
    localparam logic [2:0] POS_XYZRHW = 3'b010;
    localparam int unsigned FMT_XYZ_BIT  = 1;
    localparam int unsigned FMT_NRM_BIT  = 4;
    localparam int unsigned FMT_PSIZE_BIT = 5;
    localparam int unsigned FMT_DIF_BIT  = 6;
    localparam int unsigned FMT_SPC_BIT  = 7;
    localparam logic [3:0]  MAX_TEX_SETS = 4'd2;

    // configuration register indexes
    localparam logic CFG_FORMAT = 1'b0;
    localparam logic CFG_STRIDE = 1'b1;

    // canonical word indexes
    localparam logic [3:0] WI_X   = 4'd0;
    localparam logic [3:0] WI_Y   = 4'd1;
    localparam logic [3:0] WI_Z   = 4'd2;
    localparam logic [3:0] WI_W   = 4'd3;
    localparam logic [3:0] WI_NX  = 4'd4;
    localparam logic [3:0] WI_NY  = 4'd5;
    localparam logic [3:0] WI_NZ  = 4'd6;
    localparam logic [3:0] WI_COL = 4'd7;
    localparam logic [3:0] WI_U0  = 4'd8;
    localparam logic [3:0] WI_V0  = 4'd9;
    localparam logic [3:0] WI_U1  = 4'd10;
    localparam logic [3:0] WI_V1  = 4'd11;

    // one queued job: a rejection or a finished vertex in a store bank
    typedef struct packed {
        logic       rej;
        logic       bank;
        logic       rhw;
        logic       nrm;
        logic       dif;
        logic       spc;
        logic [1:0] tex;
    } t_vtx_cmd;

    typedef struct packed {
        logic                   en;
        logic                   bank;
        logic [WORD_ADDR_W-1:0] word_addr;
        logic [1:0]             lane;
        logic [7:0]             data;
    } t_store_wr;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_release;

endpackage

FILE: hdl/vfc_store.sv
// Double-banked vertex byte store: byte writes, word reads
module vfc_store (
    input  logic                           i_clk,
    input  vfc_pkg::t_store_wr             i_wr,
    input  logic                           i_rd_bank,
    input  logic [vfc_pkg::WORD_ADDR_W-1:0] i_rd_addr,
    output logic [31:0]                    o_rd_word
);
    import vfc_pkg::*;

    logic [3:0][7:0] r_words [STORE_BANKS][STORE_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_words[i_wr.bank][i_wr.word_addr][i_wr.lane] <= i_wr.data;
        end
    end

    // little-endian: lane 0 is the low byte
    assign o_rd_word = r_words[i_rd_bank][i_rd_addr];

endmodule

FILE: hdl/vfc_fifo.sv
// Job queue between the byte front end and the word back end
module vfc_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vfc_pkg::t_vtx_cmd i_data,
    input  logic              i_pop,
    output vfc_pkg::t_vtx_cmd o_data,
    output logic              o_empty,
    output logic              o_full
);
    import vfc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_vtx_cmd         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

endmodule

FILE: hdl/vfc_front.sv
// Front end: configuration, byte position, store writes and job classification
module vfc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [11:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_start_of_call,
    input  logic                  i_fifo_full,
    input  vfc_pkg::t_bank_release i_release,
    output logic                  o_push,
    output vfc_pkg::t_vtx_cmd     o_cmd,
    output vfc_pkg::t_store_wr    o_store_wr
);
    import vfc_pkg::*;

    logic [11:0] r_format, n_format;
    logic [7:0]  r_stride, n_stride;
    logic [7:0]  r_pos, n_pos;
    logic        r_bank, n_bank;
    logic        r_flag, n_flag;
    logic [1:0]  r_busy, n_busy;

    logic       fmt_ok, cfg_ok, accept, toggle, wr_bank, emit, cfg_wr;
    logic [1:0] tex;
    logic [5:0] size;
    logic [7:0] stride_eff, pos0, pos1;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // hold input while the queue is full or the next bank is still being read
    assign o_stall = i_fifo_full || (r_flag && r_busy[~r_bank]);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        fmt_ok = ((r_format[3:1] == POS_XYZ) || (r_format[3:1] == POS_XYZRHW))
                 && !r_format[FMT_PSIZE_BIT] && (r_format[11:8] <= MAX_TEX_SETS);
        tex    = r_format[9:8];
        size   = (r_format[FMT_XYZ_BIT] ? 6'd12 : 6'd16)
                 + (r_format[FMT_NRM_BIT] ? 6'd12 : 6'd0)
                 + (r_format[FMT_DIF_BIT] ? 6'd4 : 6'd0)
                 + (r_format[FMT_SPC_BIT] ? 6'd4 : 6'd0)
                 + {1'b0, tex, 3'b000};
        stride_eff = (r_stride == 8'd0) ? {2'b00, size} : r_stride;
        cfg_ok = fmt_ok && (stride_eff >= {2'b00, size})
                 && ({1'b0, stride_eff} <= 9'(MAX_STRIDE));

        pos0    = i_start_of_call ? 8'd0 : r_pos;
        pos1    = pos0 + 8'd1;
        // a write at offset zero after an emission opens the other bank
        toggle  = (pos0 == 8'd0) && r_flag;
        wr_bank = toggle ? ~r_bank : r_bank;
        emit    = (pos1 == {2'b00, size});

        o_store_wr.en        = accept && cfg_ok && (pos0 < 8'(LAYOUT_MAX_BYTES));
        o_store_wr.bank      = wr_bank;
        o_store_wr.word_addr = pos0[5:2];
        o_store_wr.lane      = pos0[1:0];
        o_store_wr.data      = i_data_byte;

        o_push     = accept && (!cfg_ok || emit);
        o_cmd.rej  = !cfg_ok;
        o_cmd.bank = wr_bank;
        o_cmd.rhw  = !r_format[FMT_XYZ_BIT];
        o_cmd.nrm  = r_format[FMT_NRM_BIT];
        o_cmd.dif  = r_format[FMT_DIF_BIT];
        o_cmd.spc  = r_format[FMT_SPC_BIT];
        o_cmd.tex  = tex;

        n_format = r_format;
        n_stride = r_stride;
        if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_FORMAT: n_format = i_cfg_data;
                CFG_STRIDE: n_stride = i_cfg_data[7:0];
                default:    n_format = r_format;
            endcase
        end

        n_pos  = r_pos;
        n_bank = r_bank;
        n_flag = r_flag;
        if (accept) begin
            if (cfg_ok) begin
                n_pos  = (pos1 >= stride_eff) ? 8'd0 : pos1;
                n_bank = wr_bank;
                if (emit) begin
                    n_flag = 1'b1;
                end else if (toggle) begin
                    n_flag = 1'b0;
                end
            end else begin
                n_pos = pos0;
            end
        end

        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_push && cfg_ok) begin
            n_busy[wr_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= 12'h002;
            r_stride <= 8'd0;
            r_pos    <= 8'd0;
            r_bank   <= 1'b0;
            r_flag   <= 1'b0;
            r_busy   <= 2'b00;
        end else begin
            r_format <= n_format;
            r_stride <= n_stride;
            r_pos    <= n_pos;
            r_bank   <= n_bank;
            r_flag   <= n_flag;
            r_busy   <= n_busy;
        end
    end

endmodule

FILE: hdl/vfc_back.sv
// Back end: feeds the output register twelve words per job, one if rejected
module vfc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vfc_pkg::t_vtx_cmd               i_cmd,
    input  logic                            i_empty,
    output logic                            o_pop,
    output vfc_pkg::t_bank_release          o_release,
    output logic                            o_rd_bank,
    output logic [vfc_pkg::WORD_ADDR_W-1:0] o_rd_addr,
    input  logic [31:0]                     i_rd_word,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [3:0]                      o_word_index,
    output logic [31:0]                     o_word_value,
    output logic                            o_last_word,
    output logic                            o_rejected
);
    import vfc_pkg::*;

    logic [3:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    logic [3:0]  r_index;
    logic [31:0] r_value;
    logic        r_last, r_rej;

    logic [3:0]  pos_w, col_base, tex_base, addr;
    logic        use_store, advance, produce, last;
    logic [31:0] fixed_val, value;

    always_comb begin
        pos_w    = i_cmd.rhw ? 4'd4 : 4'd3;
        col_base = pos_w + (i_cmd.nrm ? 4'd3 : 4'd0);
        tex_base = col_base + {3'b000, i_cmd.dif} + {3'b000, i_cmd.spc};

        addr      = 4'd0;
        use_store = 1'b0;
        fixed_val = 32'd0;
        unique case (r_idx)
            WI_X, WI_Y, WI_Z: begin
                addr      = r_idx;
                use_store = 1'b1;
            end
            WI_W: begin
                addr      = WI_W;
                use_store = i_cmd.rhw;
                fixed_val = ONE_FLOAT_BITS;
            end
            WI_NX, WI_NY, WI_NZ: begin
                addr      = pos_w + (r_idx - WI_NX);
                use_store = i_cmd.nrm;
            end
            WI_COL: begin
                addr      = col_base;
                use_store = i_cmd.dif;
                fixed_val = WHITE_COLOUR;
            end
            WI_U0, WI_V0: begin
                addr      = tex_base + (r_idx - WI_U0);
                use_store = (i_cmd.tex != 2'd0);
            end
            WI_U1, WI_V1: begin
                addr      = tex_base + 4'd2 + (r_idx - WI_U1);
                use_store = i_cmd.tex[1];
            end
            default: begin
                addr      = 4'd0;
                use_store = 1'b0;
            end
        endcase
        value = use_store ? i_rd_word : fixed_val;

        advance = !r_valid || !i_stall;
        produce = advance && !i_empty;
        last    = i_cmd.rej || (r_idx == WI_V1);

        o_pop             = produce && last;
        o_release.valid   = o_pop && !i_cmd.rej;
        o_release.bank    = i_cmd.bank;

        n_idx = r_idx;
        if (produce) begin
            n_idx = last ? WI_X : r_idx + 4'd1;
        end
        n_valid = advance ? produce : r_valid;
    end

    assign o_rd_bank = i_cmd.bank;
    assign o_rd_addr = addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= WI_X;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_index <= i_cmd.rej ? WI_X : r_idx;
            r_value <= i_cmd.rej ? 32'd0 : value;
            r_last  <= last;
            r_rej   <= i_cmd.rej;
        end
    end

    assign o_valid      = r_valid;
    assign o_word_index = r_index;
    assign o_word_value = r_value;
    assign o_last_word  = r_last;
    assign o_rejected   = r_rej;

endmodule

FILE: hdl/vertex_format_converter_core.sv
// Top level of the vertex format converter: front end, job queue, store, back end
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-------------------------------------
//  byte in  | in  | i_valid / o_stall            | i_data_byte, i_start_of_call
//  word out | out | o_valid / i_stall            | o_word_index, o_word_value,
//           |     |                              | o_last_word, o_rejected
//  config   | in  | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Bytes go in and words come out one per cycle each unless stalled: twelve words per
// vertex, one per refused byte. A job passes the queue, then the output register.
// Synchronous reset restores the configuration, clears the byte position and the queue.
// Input stalls when the job queue is full, or, from a vertex entering the queue to the
// next byte at offset zero, while the other store bank is being read by the back end.
`include "assert_macros.svh"

module vertex_format_converter_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_call,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_word_index,
    output logic [31:0] o_word_value,
    output logic        o_last_word,
    output logic        o_rejected
);
    import vfc_pkg::*;

    logic                   fifo_push, fifo_pop, fifo_empty, fifo_full;
    t_vtx_cmd               push_cmd, head_cmd;
    t_store_wr              store_wr;
    t_bank_release          release_info;
    logic                   rd_bank;
    logic [WORD_ADDR_W-1:0] rd_addr;
    logic [31:0]            rd_word;

    vfc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_start_of_call (i_start_of_call),
        .i_fifo_full     (fifo_full),
        .i_release       (release_info),
        .o_push          (fifo_push),
        .o_cmd           (push_cmd),
        .o_store_wr      (store_wr)
    );

    vfc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (push_cmd),
        .i_pop   (fifo_pop),
        .o_data  (head_cmd),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    vfc_store u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_bank (rd_bank),
        .i_rd_addr (rd_addr),
        .o_rd_word (rd_word)
    );

    vfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (head_cmd),
        .i_empty      (fifo_empty),
        .o_pop        (fifo_pop),
        .o_release    (release_info),
        .o_rd_bank    (rd_bank),
        .o_rd_addr    (rd_addr),
        .i_rd_word    (rd_word),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_word_index (o_word_index),
        .o_word_value (o_word_value),
        .o_last_word  (o_last_word),
        .o_rejected   (o_rejected)
    );

    `VFC_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, fifo_push, !fifo_full, "push into full queue")
    `VFC_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, fifo_pop, !fifo_empty, "pop from empty queue")
    `VFC_ASSERT_IMPLY(a_reject_shape, i_clk, i_rst_n, o_valid && o_rejected,
                      o_last_word && (o_word_index == WI_X), "malformed rejection word")
    `VFC_ASSERT_IMPLY(a_last_index, i_clk, i_rst_n, o_valid && !o_rejected,
                      o_last_word == (o_word_index == WI_V1), "last flag out of step")

endmodule
